/* hw/rtl/ltb_pkg.sv */
// ltb_pkg: shared types, register codes and fixed widths for the luma tint blend.
// Depends on nothing; the front, back and top-level files import it.
`default_nettype none

package ltb_pkg;

  localparam int CH_W       = 16;   // one color channel
  localparam int AMT_W      = 13;   // blend amount register
  localparam int COLOR_W    = 48;   // packed red, green, blue
  localparam int DATA_W     = 64;   // configuration data bus
  localparam int ADDR_W     = 6;    // registers at 8-byte spacing
  localparam int LUMA_SUM_W = 35;   // three 16x16 products plus rounding term
  localparam int MID_DEPTH  = 4;    // front-to-back queue
  localparam int OUT_DEPTH  = 8;    // result queue
  localparam int PIX_W      = 4 * CH_W;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_AMOUNT  = 3'd1,
    REG_LIGHT   = 3'd2,
    REG_DARK    = 3'd3,
    REG_WEIGHTS = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic               mode;      // 0 duotone, 1 rainbow
    logic [AMT_W-1:0]   amount;
    logic [COLOR_W-1:0] light;
    logic [COLOR_W-1:0] dark;
    logic [COLOR_W-1:0] weights;
  } cfg_t;

  // luminance width that follows from the fraction bits
  function automatic int lum_width(input int frac_bits);
    return LUMA_SUM_W - frac_bits;
  endfunction

  // channel 0 red (bits 47..32), 1 green, 2 blue (bits 15..0)
  function automatic logic [CH_W-1:0] chan_of(input logic [COLOR_W-1:0] packed_v,
                                               input int ch);
    return packed_v[CH_W*(2-ch) +: CH_W];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/ltb_fifo.sv */
// ltb_fifo: small show-ahead register queue used between the pipeline parts.
// Depends on nothing but its parameters.
`default_nettype none

module ltb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty,
  output logic                  full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic             do_wr, do_rd;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_comb begin
    count_next = count + CNT_W'(do_wr) - CNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ltb_front.sv */
// ltb_front: accepts pixels, forms the rounded luminance and tags the tint mode.
// Depends on ltb_pkg; feeds the front-to-back queue under a credit count.
`default_nettype none

module ltb_front import ltb_pkg::*; #(
  parameter int FRAC_BITS = 12,
  parameter int ITEM_W    = 1 + PIX_W + LUMA_SUM_W - FRAC_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [CH_W-1:0]   red_in,
  input  wire logic [CH_W-1:0]   green_in,
  input  wire logic [CH_W-1:0]   blue_in,
  input  wire logic [CH_W-1:0]   alpha_in,
  input  wire logic              item_pop,
  output logic                   item_wr,
  output logic [ITEM_W-1:0]      item_data
);

  localparam int LUM_W = lum_width(FRAC_BITS);
  localparam int HALF  = 1 << (FRAC_BITS - 1);
  localparam int CNT_W = $clog2(MID_DEPTH + 1);
  localparam int PROD_W = 2 * CH_W;

  logic [CNT_W-1:0]      credits, credits_next;
  logic                  accept;
  logic                  valid;
  logic                  mode_s;
  logic [CH_W-1:0]       pix [3];
  logic [CH_W-1:0]       alpha_s;
  logic [PROD_W-1:0]     prod [3];
  logic [CH_W-1:0]       pix_in [3];
  logic [LUMA_SUM_W-1:0] sum;
  logic [LUM_W-1:0]      lum;

  assign full   = (credits == '0);
  assign accept = push && !full;
  assign pix_in[0] = red_in;
  assign pix_in[1] = green_in;
  assign pix_in[2] = blue_in;

  // a credit leaves with each accepted beat and returns when the back pops it
  always_comb begin
    credits_next = credits - CNT_W'(accept) + CNT_W'(item_pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= CNT_W'(MID_DEPTH);
      valid   <= 1'b0;
    end else begin
      credits <= credits_next;
      valid   <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_s  <= cfg.mode;
      alpha_s <= alpha_in;
      for (int ch = 0; ch < 3; ch++) begin
        pix[ch]  <= pix_in[ch];
        prod[ch] <= chan_of(cfg.weights, ch) * pix_in[ch];
      end
    end
  end

  always_comb begin
    sum = LUMA_SUM_W'(prod[0]) + LUMA_SUM_W'(prod[1]) + LUMA_SUM_W'(prod[2])
        + LUMA_SUM_W'(HALF);
    lum = sum[LUMA_SUM_W-1:FRAC_BITS];
  end

  assign item_wr   = valid;
  assign item_data = {mode_s, alpha_s, pix[2], pix[1], pix[0], lum};

endmodule

`default_nettype wire

/* hw/rtl/ltb_back.sv */
// ltb_back: builds the duotone or rainbow tint, blends it and saturates.
// Depends on ltb_pkg; drains the front-to-back queue into the result queue.
`default_nettype none

module ltb_back import ltb_pkg::*; #(
  parameter int FRAC_BITS = 12,
  parameter int ITEM_W    = 1 + PIX_W + LUMA_SUM_W - FRAC_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              item_valid,
  input  wire logic [ITEM_W-1:0] item_data,
  output logic                   item_pop,
  input  wire logic              res_pop,
  output logic                   res_wr,
  output logic [PIX_W-1:0]       res_data
);

  localparam int LUM_W  = lum_width(FRAC_BITS);
  localparam int ONE    = 1 << FRAC_BITS;
  localparam int HALF   = 1 << (FRAC_BITS - 1);
  localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
  localparam int PL_W   = CH_W + LUM_W;          // light * L, unsigned
  localparam int PD_W   = LUM_W + CH_W + 2;      // dark * (ONE - L), signed
  localparam int DUO_W  = LUM_W + CH_W + 3;
  localparam int TINT_W = DUO_W - FRAC_BITS + 1;
  localparam int AMT_S  = AMT_W + 1;
  localparam int OMA_W  = AMT_W + 3;
  localparam int PT_W   = TINT_W + AMT_S;
  localparam int PC_W   = CH_W + 1 + OMA_W;
  localparam int BL_W   = TINT_W + CH_W + 1;

  localparam logic signed [TINT_W-1:0] ONE_S = TINT_W'(ONE);

  logic [CNT_W-1:0] credits, credits_next;
  logic             issue;

  // unpacked queue beat
  logic [LUM_W-1:0] lum;
  logic [CH_W-1:0]  c_in [3];
  logic [CH_W-1:0]  a_in;
  logic             mode_in;

  // tint terms
  logic signed [LUM_W:0]    oml;
  logic signed [TINT_W-1:0] d_s;
  logic signed [TINT_W-1:0] rb [3];
  logic                     low_half;

  // stage 1
  logic                     v1, mode1;
  logic [CH_W-1:0]          c1 [3];
  logic [CH_W-1:0]          a1;
  logic [PL_W-1:0]          pl1 [3];
  logic signed [PD_W-1:0]   pd1 [3];
  logic signed [TINT_W-1:0] rb1 [3];
  logic signed [DUO_W-1:0]  duo_sum [3];
  logic signed [DUO_W-1:0]  duo_shr [3];

  // stage 2
  logic                     v2;
  logic [CH_W-1:0]          c2 [3];
  logic [CH_W-1:0]          a2;
  logic signed [TINT_W-1:0] tint2 [3];
  logic signed [AMT_S-1:0]  amt_s;
  logic signed [OMA_W-1:0]  oma;

  // stage 3
  logic                     v3;
  logic [CH_W-1:0]          a3;
  logic signed [PT_W-1:0]   pt3 [3];
  logic signed [PC_W-1:0]   pc3 [3];
  logic signed [BL_W-1:0]   bl [3];
  logic signed [BL_W-1:0]   bl_shr [3];
  logic [CH_W-1:0]          res [3];

  assign issue    = item_valid && (credits != '0);
  assign item_pop = issue;

  always_comb begin
    credits_next = credits - CNT_W'(issue) + CNT_W'(res_pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= CNT_W'(OUT_DEPTH);
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
    end else begin
      credits <= credits_next;
      v1      <= issue;
      v2      <= v1;
      v3      <= v2;
    end
  end

  assign lum     = item_data[LUM_W-1:0];
  assign c_in[0] = item_data[LUM_W +: CH_W];
  assign c_in[1] = item_data[LUM_W + CH_W +: CH_W];
  assign c_in[2] = item_data[LUM_W + 2*CH_W +: CH_W];
  assign a_in    = item_data[LUM_W + 3*CH_W +: CH_W];
  assign mode_in = item_data[ITEM_W-1];

  // rainbow ramp on D = 2L; green has no floor above the midpoint
  always_comb begin
    oml      = $signed((LUM_W+1)'(ONE)) - $signed({1'b0, lum});
    d_s      = TINT_W'($signed({1'b0, lum, 1'b0}));
    low_half = (d_s <= ONE_S);
    if (low_half) begin
      rb[0] = '0;
      rb[1] = d_s;
      rb[2] = ONE_S - d_s;
    end else begin
      rb[0] = (d_s - ONE_S > ONE_S) ? ONE_S : d_s - ONE_S;
      rb[1] = ONE_S + ONE_S - d_s;
      rb[2] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      mode1 <= mode_in;
      a1    <= a_in;
      for (int ch = 0; ch < 3; ch++) begin
        c1[ch]  <= c_in[ch];
        pl1[ch] <= chan_of(cfg.light, ch) * lum;
        pd1[ch] <= $signed({1'b0, chan_of(cfg.dark, ch)}) * oml;
        rb1[ch] <= rb[ch];
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      duo_sum[ch] = DUO_W'($signed({1'b0, pl1[ch]})) + DUO_W'(pd1[ch]) + DUO_W'(HALF);
      duo_shr[ch] = duo_sum[ch] >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      a2 <= a1;
      for (int ch = 0; ch < 3; ch++) begin
        c2[ch]    <= c1[ch];
        tint2[ch] <= mode1 ? rb1[ch] : TINT_W'(duo_shr[ch]);
      end
    end
  end

  // ONE - amount wraps into a signed field; negative means extrapolation
  assign amt_s = $signed({1'b0, cfg.amount});
  assign oma   = OMA_W'(ONE) - OMA_W'(cfg.amount);

  always_ff @(posedge clk) begin
    if (v2) begin
      a3 <= a2;
      for (int ch = 0; ch < 3; ch++) begin
        pt3[ch] <= tint2[ch] * amt_s;
        pc3[ch] <= $signed({1'b0, c2[ch]}) * oma;
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      bl[ch]     = BL_W'(pt3[ch]) + BL_W'(pc3[ch]) + BL_W'(HALF);
      bl_shr[ch] = bl[ch] >>> FRAC_BITS;
      if (bl_shr[ch] < 0) begin
        res[ch] = '0;
      end else if (bl_shr[ch] > BL_W'(65535)) begin
        res[ch] = '1;
      end else begin
        res[ch] = bl_shr[ch][CH_W-1:0];
      end
    end
  end

  assign res_wr   = v3;
  assign res_data = {a3, res[2], res[1], res[0]};

endmodule

`default_nettype wire

/* hw/rtl/luma_tint_blend.sv */
// Luma tint blend, top level: one RGBA pixel in Q4.12 (FRAC_BITS fraction
// bits) per beat, one tinted pixel out per beat, alpha copied. The block takes
// a pixel every clock while full is low. A pixel passes the luminance front,
// the front-to-back queue and the tint and blend back into the result queue.
// The credit counts on the two queues (4 beats between front and back, 8
// results) let either side stall without losing a beat. Registers sit at
// byte addresses 8*i on the 64-bit configuration port and must be written
// only while the block is idle.
// Depends on ltb_pkg, ltb_fifo, ltb_front and ltb_back.
`default_nettype none

module luma_tint_blend import ltb_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  // pixels in
  input  wire logic              push,
  output logic                   full,
  input  wire logic [CH_W-1:0]   red_in,
  input  wire logic [CH_W-1:0]   green_in,
  input  wire logic [CH_W-1:0]   blue_in,
  input  wire logic [CH_W-1:0]   alpha_in,
  // pixels out
  output logic                   empty,
  input  wire logic              pop,
  output logic      [CH_W-1:0]   red_out,
  output logic      [CH_W-1:0]   green_out,
  output logic      [CH_W-1:0]   blue_out,
  output logic      [CH_W-1:0]   alpha_out
);

  localparam int LUM_W  = lum_width(FRAC_BITS);
  localparam int ITEM_W = 1 + PIX_W + LUM_W;

  cfg_t             cfg;
  reg_idx_t         reg_idx;
  logic             wr_strobe;

  logic              mid_wr, mid_pop, mid_empty, mid_full;
  logic [ITEM_W-1:0] mid_wdata, mid_rdata;
  logic              out_wr, out_pop, out_full;
  logic [PIX_W-1:0]  out_wdata, out_rdata;

  assign pready    = 1'b1;
  assign wr_strobe = psel && penable && pwrite;
  assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_strobe) begin
      unique case (reg_idx)
        REG_MODE:    cfg.mode    <= pwdata[0];
        REG_AMOUNT:  cfg.amount  <= pwdata[AMT_W-1:0];
        REG_LIGHT:   cfg.light   <= pwdata[COLOR_W-1:0];
        REG_DARK:    cfg.dark    <= pwdata[COLOR_W-1:0];
        REG_WEIGHTS: cfg.weights <= pwdata[COLOR_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:    prdata = DATA_W'(cfg.mode);
      REG_AMOUNT:  prdata = DATA_W'(cfg.amount);
      REG_LIGHT:   prdata = DATA_W'(cfg.light);
      REG_DARK:    prdata = DATA_W'(cfg.dark);
      REG_WEIGHTS: prdata = DATA_W'(cfg.weights);
      default:     prdata = '0;
    endcase
  end

  ltb_front #(
    .FRAC_BITS (FRAC_BITS),
    .ITEM_W    (ITEM_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .full      (full),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .alpha_in  (alpha_in),
    .item_pop  (mid_pop),
    .item_wr   (mid_wr),
    .item_data (mid_wdata)
  );

  ltb_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_wr),
    .wr_data (mid_wdata),
    .rd_en   (mid_pop),
    .rd_data (mid_rdata),
    .empty   (mid_empty),
    .full    (mid_full)
  );

  ltb_back #(
    .FRAC_BITS (FRAC_BITS),
    .ITEM_W    (ITEM_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (!mid_empty),
    .item_data  (mid_rdata),
    .item_pop   (mid_pop),
    .res_pop    (out_pop),
    .res_wr     (out_wr),
    .res_data   (out_wdata)
  );

  assign out_pop = pop && !empty;

  ltb_fifo #(
    .WIDTH (PIX_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_wr),
    .wr_data (out_wdata),
    .rd_en   (out_pop),
    .rd_data (out_rdata),
    .empty   (empty),
    .full    (out_full)
  );

  assign red_out   = out_rdata[0 +: CH_W];
  assign green_out = out_rdata[CH_W +: CH_W];
  assign blue_out  = out_rdata[2*CH_W +: CH_W];
  assign alpha_out = out_rdata[3*CH_W +: CH_W];

  // credits must keep both queues from overflowing
  a_mid_no_overflow: assert property (@(posedge clk) disable iff (rst)
    mid_wr |-> (!mid_full || mid_pop))
    else $error("front wrote a beat into a full queue");

  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    out_wr |-> (!out_full || out_pop))
    else $error("back wrote a result into a full queue");

  a_back_pops_real_beat: assert property (@(posedge clk) disable iff (rst)
    mid_pop |-> !mid_empty)
    else $error("back popped an empty queue");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> (empty && mid_empty))
    else $error("queues not empty after reset");

endmodule

`default_nettype wire
